// ----- sv/slrb_pkg.sv -----
// types and constants shared by the subpicture rle luma blend block
// no dependencies; compiled first
package slrb_pkg;

  localparam int CODE_W    = 16;
  localparam int LEN_W     = 14;
  localparam int LUMA_W    = 8;
  localparam int ALPHA_W   = 4;
  localparam int IDX_W     = 2;
  localparam int SIZE_W    = 11;
  localparam int BOX_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_LUMA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_ALPHA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPU_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPU_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_ENABLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_COLUMNS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_ROWS     = 3'd6;

  localparam logic OP_CODE   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 4'h0;
  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 4'hf;

  localparam logic [SIZE_W-1:0]  SIZE_RESET = 11'd1024;
  localparam logic [2*BOX_W-1:0] BOX_RESET  = 20'hffc00;

  typedef struct packed {
    logic [3:0][LUMA_W-1:0]  palette_luma;
    logic [3:0][ALPHA_W-1:0] palette_alpha;
    logic [SIZE_W-1:0]       spu_width;
    logic [SIZE_W-1:0]       spu_height;
    logic                    crop_enable;
    logic [2*BOX_W-1:0]      crop_columns;
    logic [2*BOX_W-1:0]      crop_rows;
  } slrb_cfg_t;

  // one classified sample on its way to the blender
  typedef struct packed {
    logic [LUMA_W-1:0] bg;
    logic [IDX_W-1:0]  idx;
    logic              blend_en;
    logic              status;
    logic              line_end;
    logic              frame_end;
  } slrb_entry_t;

  typedef struct packed {
    logic [LUMA_W-1:0] blended_luma;
    logic              status;
    logic              line_end;
    logic              frame_end;
  } slrb_result_t;

endpackage

// ----- sv/slrb_if.sv -----
// valid/ready channel interfaces for input items and result items
// depends on slrb_pkg
interface slrb_in_if;
  import slrb_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [CODE_W-1:0] code_word;
  logic [LUMA_W-1:0] background_luma;
  modport source(output valid, op, code_word, background_luma, input ready);
  modport sink(input valid, op, code_word, background_luma, output ready);
endinterface

interface slrb_out_if;
  import slrb_pkg::*;
  logic              valid;
  logic              ready;
  logic [LUMA_W-1:0] blended_luma;
  logic              status;
  logic              line_end;
  logic              frame_end;
  modport source(output valid, blended_luma, status, line_end, frame_end, input ready);
  modport sink(input valid, blended_luma, status, line_end, frame_end, output ready);
endinterface

// ----- sv/subpicture_rle_luma_blend_top.sv -----
// top level of the subpicture rle luma blend: config registers, front end,
// queue and blender; depends on slrb_pkg, slrb_if, slrb_front, slrb_fifo, slrb_back
//
//   channel  role    handshake        payload
//   in_if    sink    valid/ready      op, code_word, background_luma
//   out_if   source  valid/ready      blended_luma, status, line_end, frame_end
//   cfg_*    write   cfg_we           cfg_index, cfg_wdata
//
// one item per cycle sustained while the queue is not full; a sample is written into
// the queue at the edge that takes it, then blended into the output register once that is free
// run and position state update in the front end in the cycle an item is taken
// rst_n is synchronous; state, queue and output are empty after reset
// a stalled output fills the four-entry queue, then in_if.ready drops
module subpicture_rle_luma_blend_top #(
  parameter int MAX_DIM = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  slrb_in_if.sink                        in_if,
  slrb_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [slrb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slrb_pkg::CFG_DW-1:0]    cfg_wdata
);
  import slrb_pkg::*;

  slrb_cfg_t    cfg_r;
  slrb_entry_t  f_entry, q_data;
  slrb_result_t out_data;
  logic         accept, f_push, q_full, q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.palette_luma  <= '0;
      cfg_r.palette_alpha <= '0;
      cfg_r.spu_width     <= SIZE_RESET;
      cfg_r.spu_height    <= SIZE_RESET;
      cfg_r.crop_enable   <= 1'b0;
      cfg_r.crop_columns  <= BOX_RESET;
      cfg_r.crop_rows     <= BOX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PALETTE_LUMA:  cfg_r.palette_luma  <= cfg_wdata;
        REG_PALETTE_ALPHA: cfg_r.palette_alpha <= cfg_wdata[4*ALPHA_W-1:0];
        REG_SPU_WIDTH:     cfg_r.spu_width     <= cfg_wdata[SIZE_W-1:0];
        REG_SPU_HEIGHT:    cfg_r.spu_height    <= cfg_wdata[SIZE_W-1:0];
        REG_CROP_ENABLE:   cfg_r.crop_enable   <= cfg_wdata[0];
        REG_CROP_COLUMNS:  cfg_r.crop_columns  <= cfg_wdata[2*BOX_W-1:0];
        REG_CROP_ROWS:     cfg_r.crop_rows     <= cfg_wdata[2*BOX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;

  slrb_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .accept          (accept),
    .op              (in_if.op),
    .code_word       (in_if.code_word),
    .background_luma (in_if.background_luma),
    .push            (f_push),
    .entry           (f_entry)
  );

  slrb_fifo #(
    .DEPTH(4)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .wr_data   (f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_data   (q_data)
  );

  slrb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_data)
  );

  assign out_if.blended_luma = out_data.blended_luma;
  assign out_if.status       = out_data.status;
  assign out_if.line_end     = out_data.line_end;
  assign out_if.frame_end    = out_data.frame_end;

endmodule

// ----- sv/slrb_front.sv -----
// front end: run decoding, position tracking and crop test per item
// depends on slrb_pkg; feeds slrb_fifo
module slrb_front #(
  parameter int MAX_DIM = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  slrb_pkg::slrb_cfg_t            cfg,
  input  logic                           accept,
  input  logic                           op,
  input  logic [slrb_pkg::CODE_W-1:0]    code_word,
  input  logic [slrb_pkg::LUMA_W-1:0]    background_luma,
  output logic                           push,
  output slrb_pkg::slrb_entry_t          entry
);
  import slrb_pkg::*;

  localparam int PW  = $clog2(MAX_DIM);
  localparam int RW  = $clog2(MAX_DIM + 1);
  localparam int XW0 = (RW > LEN_W) ? RW : LEN_W;
  localparam int XW  = (XW0 > SIZE_W) ? XW0 : SIZE_W;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_DIM);

  logic [IDX_W-1:0] run_idx_r, run_idx_nxt;
  logic [RW-1:0]    run_rem_r, run_rem_nxt;
  logic             run_vis_r, run_vis_nxt;
  logic [PW-1:0]    column_r, column_nxt;
  logic [PW-1:0]    row_r, row_nxt;

  logic [XW-1:0] weff, heff, col_x, row_x, rest, len;
  logic          col_in, row_in, line_end, frame_end;

  always_comb begin
    if (cfg.spu_width == '0) begin
      weff = XW'(1);
    end else if (XW'(cfg.spu_width) > MAX_X) begin
      weff = MAX_X;
    end else begin
      weff = XW'(cfg.spu_width);
    end
    if (cfg.spu_height == '0) begin
      heff = XW'(1);
    end else if (XW'(cfg.spu_height) > MAX_X) begin
      heff = MAX_X;
    end else begin
      heff = XW'(cfg.spu_height);
    end
  end

  assign col_x = XW'(column_r);
  assign row_x = XW'(row_r);
  assign rest  = (col_x < weff) ? (weff - col_x) : XW'(1);

  always_comb begin
    len = XW'(code_word[CODE_W-1:IDX_W]);
    if (len == '0 || len > rest) begin
      len = rest;
    end
  end

  assign col_in = (col_x >= XW'(cfg.crop_columns[BOX_W-1:0])) &&
                  (col_x <= XW'(cfg.crop_columns[2*BOX_W-1:BOX_W]));
  assign row_in = (row_x >= XW'(cfg.crop_rows[BOX_W-1:0])) &&
                  (row_x <= XW'(cfg.crop_rows[2*BOX_W-1:BOX_W]));
  assign line_end  = (col_x + XW'(1)) >= weff;
  assign frame_end = (row_x + XW'(1)) >= heff;

  always_comb begin
    run_idx_nxt = run_idx_r;
    run_rem_nxt = run_rem_r;
    run_vis_nxt = run_vis_r;
    column_nxt  = column_r;
    row_nxt     = row_r;
    push        = 1'b0;
    entry.bg        = background_luma;
    entry.idx       = run_idx_r;
    entry.blend_en  = run_vis_r;
    entry.status    = 1'b0;
    entry.line_end  = 1'b0;
    entry.frame_end = 1'b0;
    if (accept) begin
      if (op == OP_CODE) begin
        run_idx_nxt = code_word[IDX_W-1:0];
        run_rem_nxt = len[RW-1:0];
        run_vis_nxt = !cfg.crop_enable || (col_in && row_in);
      end else begin
        push = 1'b1;
        if (run_rem_r == '0) begin
          entry.status   = 1'b1;
          entry.blend_en = 1'b0;
        end else begin
          entry.line_end = line_end;
          run_rem_nxt    = run_rem_r - RW'(1);
          if (line_end) begin
            entry.frame_end = frame_end;
            column_nxt      = '0;
            run_rem_nxt     = '0;
            row_nxt         = frame_end ? '0 : row_r + PW'(1);
          end else begin
            column_nxt = column_r + PW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_idx_r <= '0;
      run_rem_r <= '0;
      run_vis_r <= 1'b0;
      column_r  <= '0;
      row_r     <= '0;
    end else begin
      run_idx_r <= run_idx_nxt;
      run_rem_r <= run_rem_nxt;
      run_vis_r <= run_vis_nxt;
      column_r  <= column_nxt;
      row_r     <= row_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (push && entry.line_end) |=> (run_rem_r == '0 && column_r == '0))
    else $error("line end did not clear run and column");
  a_status_no_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && entry.status) |=> ($stable(column_r) && $stable(row_r)))
    else $error("position moved on a sample without a run");
  a_code_sets_run: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_CODE) |=> (run_rem_r != '0))
    else $error("code word left no active run");
`endif

endmodule

// ----- sv/slrb_fifo.sv -----
// short queue of classified samples between front end and blender
// depends on slrb_pkg
module slrb_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  slrb_pkg::slrb_entry_t wr_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  not_empty,
  output slrb_pkg::slrb_entry_t rd_data
);
  import slrb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  slrb_entry_t    mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count missed a push");
  a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("queue count missed a pop");
`endif

endmodule

// ----- sv/slrb_back.sv -----
// back end: palette lookup, alpha blend and output register
// depends on slrb_pkg; fed by slrb_fifo
module slrb_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  slrb_pkg::slrb_cfg_t   cfg,
  input  logic                  q_valid,
  input  slrb_pkg::slrb_entry_t q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output slrb_pkg::slrb_result_t out_data
);
  import slrb_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  slrb_result_t      out_data_r;
  logic [LUMA_W-1:0] luma, res;
  logic [ALPHA_W-1:0] alpha;
  logic [12:0]       mix;
  logic              load;

  assign luma  = cfg.palette_luma[q_data.idx];
  assign alpha = cfg.palette_alpha[q_data.idx];
  assign mix   = 13'(luma) * 13'({1'b0, alpha} + 5'd1) +
                 13'(q_data.bg) * 13'(ALPHA_OPAQUE - alpha);

  always_comb begin
    if (!q_data.blend_en || alpha == ALPHA_CLEAR) begin
      res = q_data.bg;
    end else if (alpha == ALPHA_OPAQUE) begin
      res = luma;
    end else begin
      res = mix[11:4];
    end
  end

  assign load          = q_valid && (!out_valid_r || out_ready);
  assign q_pop         = load;
  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.blended_luma <= res;
      out_data_r.status       <= q_data.status;
      out_data_r.line_end     <= q_data.line_end;
      out_data_r.frame_end    <= q_data.frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- test/tb_subpicture_rle_luma_blend_top.sv -----
// self-checking testbench for subpicture_rle_luma_blend_top: directed and random
// run/sample streams checked against an in-bench blend predictor
// depends on slrb_pkg, slrb_if and the rtl under sv/
`timescale 1ns / 1ps

module tb_subpicture_rle_luma_blend_top;
  import slrb_pkg::*;

  localparam int MAX_DIM = 1024;
  localparam int IDLE_LIMIT = 1000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DW-1:0]    cfg_wdata;

  slrb_in_if  in_if();
  slrb_out_if out_if();

  subpicture_rle_luma_blend_top #(.MAX_DIM(MAX_DIM)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .out_if(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // register mirror
  logic [31:0]         pal_luma_m   = '0;
  logic [15:0]         pal_alpha_m  = '0;
  logic [SIZE_W-1:0]   width_m      = SIZE_RESET;
  logic [SIZE_W-1:0]   height_m     = SIZE_RESET;
  logic                crop_en_m    = 1'b0;
  logic [2*BOX_W-1:0]  crop_cols_m  = BOX_RESET;
  logic [2*BOX_W-1:0]  crop_rows_m  = BOX_RESET;

  // run and position tracking
  logic [IDX_W-1:0] run_idx = '0;
  int unsigned      run_left = 0;
  bit               run_vis = 1'b0;
  int unsigned      col = 0;
  int unsigned      row_pos = 0;

  slrb_result_t pending_blends[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           items_sent = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic bit in_box(int unsigned pos, logic [2*BOX_W-1:0] box);
    return pos >= box[BOX_W-1:0] && pos <= box[2*BOX_W-1:BOX_W];
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] data);
    case (idx)
      REG_PALETTE_LUMA:  pal_luma_m = data;
      REG_PALETTE_ALPHA: pal_alpha_m = data[15:0];
      REG_SPU_WIDTH:     width_m = data[SIZE_W-1:0];
      REG_SPU_HEIGHT:    height_m = data[SIZE_W-1:0];
      REG_CROP_ENABLE:   crop_en_m = data[0];
      REG_CROP_COLUMNS:  crop_cols_m = data[2*BOX_W-1:0];
      REG_CROP_ROWS:     crop_rows_m = data[2*BOX_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_blend(logic op, logic [CODE_W-1:0] code,
                                        logic [LUMA_W-1:0] bg);
    int unsigned  w_eff, h_eff, len, rest, alpha, luma, mix;
    slrb_result_t res;
    w_eff = clamp_dim(width_m);
    h_eff = clamp_dim(height_m);
    if (op == OP_CODE) begin
      len = code[CODE_W-1:IDX_W];
      rest = (col < w_eff) ? w_eff - col : 1;
      if (len == 0 || len > rest) len = rest;
      run_idx = code[IDX_W-1:0];
      run_left = len;
      run_vis = !crop_en_m || (in_box(col, crop_cols_m) && in_box(row_pos, crop_rows_m));
      return;
    end
    res = '0;
    if (run_left == 0) begin
      res.blended_luma = bg;
      res.status = 1'b1;
      pending_blends.push_back(res);
      return;
    end
    alpha = pal_alpha_m[ALPHA_W*run_idx +: ALPHA_W];
    luma = pal_luma_m[LUMA_W*run_idx +: LUMA_W];
    if (!run_vis || alpha == ALPHA_CLEAR) mix = bg;
    else if (alpha == ALPHA_OPAQUE) mix = luma;
    else mix = (luma * (alpha + 1) + bg * (15 - alpha)) >> 4;
    res.blended_luma = mix[LUMA_W-1:0];
    run_left--;
    if (col + 1 >= w_eff) begin
      res.line_end = 1'b1;
      col = 0;
      run_left = 0;
      res.frame_end = (row_pos + 1 >= h_eff);
      row_pos = res.frame_end ? 0 : row_pos + 1;
    end else begin
      col++;
    end
    pending_blends.push_back(res);
  endfunction

  function automatic void check_blend();
    slrb_result_t exp_r;
    if (pending_blends.size() == 0) begin
      $error("result with no item waiting: blended_luma %0h", out_if.blended_luma);
      mismatches++;
      return;
    end
    exp_r = pending_blends.pop_front();
    if (out_if.blended_luma !== exp_r.blended_luma) begin
      $error("blended_luma: expected %0h, got %0h", exp_r.blended_luma, out_if.blended_luma);
      mismatches++;
    end
    if (out_if.status !== exp_r.status) begin
      $error("status: expected %0b, got %0b", exp_r.status, out_if.status);
      mismatches++;
    end
    if (out_if.line_end !== exp_r.line_end) begin
      $error("line_end: expected %0b, got %0b", exp_r.line_end, out_if.line_end);
      mismatches++;
    end
    if (out_if.frame_end !== exp_r.frame_end) begin
      $error("frame_end: expected %0b, got %0b", exp_r.frame_end, out_if.frame_end);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) apply_register(cfg_index, cfg_wdata);
      if (out_if.valid && out_if.ready) check_blend();
      if (in_if.valid && in_if.ready)
        predict_blend(in_if.op, in_if.code_word, in_if.background_luma);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("subpicture_rle_luma_blend_top: mismatch");
        $finish;
      end
    end
  end

  task automatic send_item(input logic op, input logic [CODE_W-1:0] code,
                           input logic [LUMA_W-1:0] bg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.code_word <= code;
    in_if.background_luma <= bg;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_blends.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] luma, input logic [15:0] alpha,
                                input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                                input logic crop_en, input logic [2*BOX_W-1:0] cols,
                                input logic [2*BOX_W-1:0] rows);
    logic [CFG_IDX_W-1:0] idx_list[7];
    logic [CFG_DW-1:0]    val_list[7];
    drain();
    idx_list = '{REG_PALETTE_LUMA, REG_PALETTE_ALPHA, REG_SPU_WIDTH, REG_SPU_HEIGHT,
                 REG_CROP_ENABLE, REG_CROP_COLUMNS, REG_CROP_ROWS};
    val_list = '{luma, CFG_DW'(alpha), CFG_DW'(w), CFG_DW'(h), CFG_DW'(crop_en),
                 CFG_DW'(cols), CFG_DW'(rows)};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_wdata <= val_list[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // fill-to-end run followed by its samples
  task automatic fill_run(input int unsigned n, input logic [IDX_W-1:0] idx);
    send_item(OP_CODE, {14'd0, idx}, 8'($urandom));
    repeat (n) send_item(OP_SAMPLE, 16'($urandom), 8'($urandom));
  endtask

  // only called when idle, so the tracked position is settled
  task automatic rewind_frame();
    int unsigned w_eff, h_eff, n, lines;
    w_eff = clamp_dim(width_m);
    h_eff = clamp_dim(height_m);
    n = (col < w_eff) ? w_eff - col : 1;
    lines = (row_pos + 1 >= h_eff) ? 0 : h_eff - row_pos - 1;
    fill_run(n, 2'($urandom));
    repeat (lines) fill_run(w_eff, 2'($urandom));
  endtask

  task automatic test_no_run();
    send_item(OP_SAMPLE, 16'h0000, 8'h00);
    send_item(OP_SAMPLE, 16'hffff, 8'hff);
  endtask

  task automatic test_blend_modes();
    apply_settings(32'h3c8000ff, 16'h170f, 11'd8, 11'd2, 1'b0, BOX_RESET, BOX_RESET);
    send_item(OP_CODE, {14'd1, 2'd0}, 8'h00);
    send_item(OP_SAMPLE, 16'h0000, 8'h40);
    send_item(OP_CODE, {14'd1, 2'd1}, 8'h00);
    send_item(OP_SAMPLE, 16'h0000, 8'hff);
    send_item(OP_CODE, {14'd1, 2'd2}, 8'h00);
    send_item(OP_SAMPLE, 16'h0000, 8'hff);
    send_item(OP_CODE, {14'd1, 2'd3}, 8'h00);
    send_item(OP_SAMPLE, 16'h0000, 8'h00);
  endtask

  task automatic test_run_lengths();
    fill_run(4, 2'd2);
    send_item(OP_SAMPLE, 16'h0000, 8'h5a);
    send_item(OP_CODE, {14'h3fff, 2'd3}, 8'h00);
    repeat (3) send_item(OP_SAMPLE, 16'h0000, 8'($urandom));
    send_item(OP_CODE, {14'd2, 2'd0}, 8'h00);
    repeat (2) send_item(OP_SAMPLE, 16'h0000, 8'($urandom));
    send_item(OP_SAMPLE, 16'h0000, 8'ha5);
  endtask

  task automatic test_crop();
    apply_settings(32'h3c8000ff, 16'h170f, 11'd4, 11'd2, 1'b1, 20'h00c02, 20'h00401);
    rewind_frame();
    send_item(OP_CODE, {14'd2, 2'd0}, 8'h00);
    repeat (2) send_item(OP_SAMPLE, 16'h0000, 8'h11);
    fill_run(2, 2'd0);
    send_item(OP_CODE, {14'd2, 2'd0}, 8'h00);
    repeat (2) send_item(OP_SAMPLE, 16'h0000, 8'h11);
    fill_run(2, 2'd0);
  endtask

  task automatic test_size_limits();
    apply_settings(32'h3c8000ff, 16'h170f, 11'd0, 11'd0, 1'b0, BOX_RESET, BOX_RESET);
    send_item(OP_CODE, {14'd5, 2'd0}, 8'h00);
    send_item(OP_SAMPLE, 16'h0000, 8'h22);
    apply_settings(32'h3c8000ff, 16'h170f, 11'd2047, 11'd2047, 1'b0, BOX_RESET, BOX_RESET);
    send_item(OP_CODE, {14'h3fff, 2'd2}, 8'h00);
    repeat (3) send_item(OP_SAMPLE, 16'h0000, 8'($urandom));
    apply_settings(32'h3c8000ff, 16'h170f, 11'd2, 11'd1, 1'b0, BOX_RESET, BOX_RESET);
    send_item(OP_CODE, {14'd7, 2'd1}, 8'h00);
    send_item(OP_SAMPLE, 16'h0000, 8'h33);
  endtask

  task automatic random_settings();
    logic [SIZE_W-1:0]  w, h;
    logic [2*BOX_W-1:0] cb, rb;
    logic [15:0]        alpha;
    int unsigned        first;
    case ($urandom_range(0, 19))
      0: w = 11'd0;
      1: w = 11'd2047;
      2: w = 11'd1024;
      default: w = 11'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 19))
      0: h = 11'd0;
      1: h = 11'd2047;
      default: h = 11'($urandom_range(1, 6));
    endcase
    first = $urandom_range(0, 6);
    cb = ($urandom_range(0, 3) == 0) ? 20'($urandom) :
         {10'($urandom_range(first, 10)), 10'(first)};
    first = $urandom_range(0, 4);
    rb = ($urandom_range(0, 3) == 0) ? 20'($urandom) :
         {10'($urandom_range(first, 6)), 10'(first)};
    case ($urandom_range(0, 9))
      0: alpha = 16'h0000;
      1: alpha = 16'hffff;
      default: alpha = 16'($urandom);
    endcase
    apply_settings($urandom, alpha, w, h, 1'($urandom), cb, rb);
    if (clamp_dim(w) * clamp_dim(h) <= 96 && $urandom_range(0, 1) == 0) rewind_frame();
  endtask

  task automatic random_burst();
    int unsigned len, n, roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      send_item(OP_SAMPLE, 16'($urandom), 8'($urandom));
      return;
    end
    roll = $urandom_range(0, 99);
    if (roll < 15) len = 0;
    else if (roll < 30) len = $urandom_range(0, 16383);
    else len = $urandom_range(1, 12);
    n = $urandom_range(0, ((len == 0 || len > 12) ? 12 : len) + 1);
    send_item(OP_CODE, {14'(len), 2'($urandom)}, 8'($urandom));
    repeat (n) send_item(OP_SAMPLE, 16'($urandom), 8'($urandom));
  endtask

  task automatic test_random(input int count);
    int target, next_settings;
    target = items_sent + count;
    next_settings = items_sent;
    while (items_sent < target) begin
      if (items_sent >= next_settings) begin
        random_settings();
        next_settings = items_sent + $urandom_range(60, 150);
      end
      random_burst();
    end
    // hold off until everything is out
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.op = OP_CODE;
    in_if.code_word = '0;
    in_if.background_luma = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 25;
    recv_idle_pct = 69;
    test_no_run();
    test_blend_modes();
    test_run_lengths();
    test_crop();
    test_size_limits();
    test_random(340);

    send_idle_pct = 69;
    recv_idle_pct = 25;
    test_random(330);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(330);

    in_if.valid <= 1'b0;
    while (pending_blends.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("subpicture_rle_luma_blend_top: match");
    else $display("subpicture_rle_luma_blend_top: mismatch");
    $finish;
  end

endmodule
